FILE: rtl/dual_median_obstacle_detector_unit_assert.svh
// Assertion macros shared by the checker files of the obstacle detector.
// Every macro expects signals named clk and rst_n in the including scope.
`ifndef DUAL_MEDIAN_OBSTACLE_DETECTOR_UNIT_ASSERT_SVH
`define DUAL_MEDIAN_OBSTACLE_DETECTOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMOD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold later than the antecedent, not in the same cycle.
`define DMOD_ASSERT_TWO(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

FILE: rtl/dmod_pkg.sv
// Shared types and constants of the dual median obstacle detector.
// No dependencies; every other .sv file under rtl imports this package.
package dmod_pkg;

  localparam int RAW_W = 16;
  localparam int VAL_W = 14;
  localparam int RC_W  = 3;

  localparam logic [VAL_W-1:0] NOT_READY = 14'd9999;

  // Raw codes that the sensors report on failure.
  localparam logic [RAW_W-1:0] FAULT_ZERO  = 16'd0;
  localparam logic [RAW_W-1:0] FAULT_LOW   = 16'd20;
  localparam logic [RAW_W-1:0] FAULT_HIGH  = 16'd8190;
  localparam logic [RAW_W-1:0] FAULT_RANGE = 16'd9999;

  localparam logic [VAL_W-1:0] ACCEPT_MIN_RST  = 14'd30;
  localparam logic [VAL_W-1:0] ACCEPT_MAX_RST  = 14'd2000;
  localparam logic [VAL_W-1:0] STOP_DIST_RST   = 14'd200;
  localparam logic [RC_W-1:0]  READY_COUNT_RST = 3'd3;

  typedef enum logic [1:0] {
    CFG_ACCEPT_MIN  = 2'd0,
    CFG_ACCEPT_MAX  = 2'd1,
    CFG_STOP_DIST   = 2'd2,
    CFG_READY_COUNT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [RAW_W-1:0] left_raw;
    logic [RAW_W-1:0] right_raw;
  } dmod_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] left_median;
    logic [VAL_W-1:0] right_median;
    logic             obstacle;
    logic             obstacle_changed;
  } dmod_out_t;

  // Median of one side as handed from the selector to the top level.
  typedef struct packed {
    logic [VAL_W-1:0] median;
    logic             ready;
  } side_res_t;

endpackage

FILE: rtl/dual_median_obstacle_detector_unit.sv
// Accepted items enter the rings; their results are registered in out_data_r.
// Throughput: one item per cycle while the output is not stalled; the ring
// update and the rank-select median each take one register stage.
// Reset (synchronous, rst_n low) restores the register defaults and empties
// both rings by clearing their fill counts; no clearing pass is needed.
// Depends on dmod_pkg, dmod_ring and dmod_select.
module dual_median_obstacle_detector_unit #(
  parameter int WINDOW = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dmod_pkg::dmod_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dmod_pkg::dmod_out_t                out_data,
  input  logic                               cfg_we,
  input  dmod_pkg::cfg_idx_t                 cfg_index,
  input  logic [dmod_pkg::VAL_W-1:0]         cfg_wdata
);
  import dmod_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [VAL_W-1:0] accept_min_r, accept_max_r, stop_dist_r;
  logic [RC_W-1:0]  ready_count_r;

  logic             s1_valid_r, s1_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  dmod_out_t        out_data_r, out_data_nxt;
  logic             obstacle_r, obstacle_nxt;
  logic             advance;
  logic             in_accept;

  logic [WINDOW-1:0][VAL_W-1:0] left_ring, right_ring;
  logic [CNT_W-1:0]             left_fill, right_fill;
  side_res_t                    left_res, right_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_min_r  <= ACCEPT_MIN_RST;
      accept_max_r  <= ACCEPT_MAX_RST;
      stop_dist_r   <= STOP_DIST_RST;
      ready_count_r <= READY_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACCEPT_MIN:  accept_min_r  <= cfg_wdata;
        CFG_ACCEPT_MAX:  accept_max_r  <= cfg_wdata;
        CFG_STOP_DIST:   stop_dist_r   <= cfg_wdata;
        CFG_READY_COUNT: ready_count_r <= cfg_wdata[RC_W-1:0];
        default:         accept_min_r  <= accept_min_r;
      endcase
    end
  end

  // The rings themselves are the first stage: an accepted item updates them,
  // and the next cycle the selectors read the updated contents.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  dmod_ring #(.WINDOW(WINDOW)) u_left_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (in_accept),
    .raw        (in_data.left_raw),
    .accept_min (accept_min_r),
    .accept_max (accept_max_r),
    .ring       (left_ring),
    .fill       (left_fill)
  );

  dmod_ring #(.WINDOW(WINDOW)) u_right_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (in_accept),
    .raw        (in_data.right_raw),
    .accept_min (accept_min_r),
    .accept_max (accept_max_r),
    .ring       (right_ring),
    .fill       (right_fill)
  );

  dmod_select #(.WINDOW(WINDOW)) u_left_sel (
    .ring        (left_ring),
    .fill        (left_fill),
    .ready_count (ready_count_r),
    .res         (left_res)
  );

  dmod_select #(.WINDOW(WINDOW)) u_right_sel (
    .ring        (right_ring),
    .fill        (right_fill),
    .ready_count (ready_count_r),
    .res         (right_res)
  );

  always_comb begin
    s1_valid_nxt = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    obstacle_nxt = (left_res.ready && (left_res.median < stop_dist_r)) ||
                   (right_res.ready && (right_res.median < stop_dist_r));
    out_data_nxt.left_median      = left_res.median;
    out_data_nxt.right_median     = right_res.median;
    out_data_nxt.obstacle         = obstacle_nxt;
    out_data_nxt.obstacle_changed = obstacle_nxt ^ obstacle_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      obstacle_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        obstacle_r <= obstacle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/dmod_ring.sv
// Sample ring of one sensor side: acceptance check, write pointer and fill count.
// Depends on dmod_pkg.
module dmod_ring #(
  parameter int WINDOW = 7,
  localparam int IDX_W = $clog2(WINDOW),
  localparam int CNT_W = $clog2(WINDOW + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push_en,
  input  logic [dmod_pkg::RAW_W-1:0]            raw,
  input  logic [dmod_pkg::VAL_W-1:0]            accept_min,
  input  logic [dmod_pkg::VAL_W-1:0]            accept_max,
  output logic [WINDOW-1:0][dmod_pkg::VAL_W-1:0] ring,
  output logic [CNT_W-1:0]                      fill
);
  import dmod_pkg::*;

  logic [WINDOW-1:0][VAL_W-1:0] ring_r;
  logic [IDX_W-1:0]             pos_r, pos_nxt;
  logic [CNT_W-1:0]             fill_r, fill_nxt;
  logic                         reading_ok;
  logic                         push;

  always_comb begin
    reading_ok = (raw != FAULT_ZERO) && (raw != FAULT_LOW) &&
                 (raw != FAULT_HIGH) && (raw != FAULT_RANGE) &&
                 (raw >= {2'b00, accept_min}) && (raw <= {2'b00, accept_max});
    push = push_en && reading_ok;
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    if (push) begin
      pos_nxt = (pos_r == IDX_W'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
      if (fill_r != CNT_W'(WINDOW)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Entries past the fill count are never read, so the ring needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ring_r[pos_r] <= raw[VAL_W-1:0];
    end
  end

  assign ring = ring_r;
  assign fill = fill_r;

endmodule

FILE: rtl/dmod_select.sv
// Rank-based median selector over the valid entries of one ring.
// Depends on dmod_pkg.
module dmod_select #(
  parameter int WINDOW = 7,
  localparam int CNT_W = $clog2(WINDOW + 1),
  localparam int CMP_W = (CNT_W > dmod_pkg::RC_W) ? CNT_W : dmod_pkg::RC_W
) (
  input  logic [WINDOW-1:0][dmod_pkg::VAL_W-1:0] ring,
  input  logic [CNT_W-1:0]                       fill,
  input  logic [dmod_pkg::RC_W-1:0]              ready_count,
  output dmod_pkg::side_res_t                    res
);
  import dmod_pkg::*;

  logic [WINDOW-1:0][WINDOW-1:0] below;
  logic [WINDOW-1:0][CNT_W-1:0]  rank;
  logic [WINDOW-1:0]             hit;
  logic [VAL_W-1:0]              picked;
  logic [CNT_W-1:0]              mid;
  logic                          ready;

  // An entry's rank counts the valid entries that sort before it; equal
  // values are ordered by position so every rank is unique.
  always_comb begin
    mid = fill >> 1;
    picked = '0;
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW; j++) begin
        below[i][j] = (CNT_W'(j) < fill) && (j != i) &&
                      ((ring[j] < ring[i]) || ((ring[j] == ring[i]) && (j < i)));
      end
      rank[i] = CNT_W'($countones(below[i]));
      hit[i]  = (CNT_W'(i) < fill) && (rank[i] == mid);
      picked  = picked | (hit[i] ? ring[i] : '0);
    end
    ready = (fill != '0) && (CMP_W'(fill) >= CMP_W'(ready_count));
    res.ready  = ready;
    res.median = ready ? picked : NOT_READY;
  end

endmodule

FILE: rtl/dmod_checker.sv
// Port-level checker for the obstacle detector and its bind to the top level.
// Depends on dmod_pkg and the assertion macro header.
`include "dual_median_obstacle_detector_unit_assert.svh"

module dmod_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input dmod_pkg::dmod_out_t        out_data
);
  import dmod_pkg::*;

  logic in_take;
  logic out_held;

  assign in_take  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;

  `DMOD_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled item changed")

  // After an accepted item passes the ring register, out_valid must be high.
  `DMOD_ASSERT_TWO(a_latency, in_take, out_valid, "accepted item produced no result")

  // A free output side never holds back the input.
  `DMOD_ASSERT_SAME(a_no_stall, !out_stall, !in_stall, "input stalled while output free")

  // An obstacle needs a side that reported a real median.
  `DMOD_ASSERT_SAME(a_obst_ready, out_valid && out_data.obstacle,
    (out_data.left_median != NOT_READY) || (out_data.right_median != NOT_READY),
    "obstacle raised without a ready median")

endmodule

bind dual_median_obstacle_detector_unit dmod_checker u_dmod_checker (.*);

FILE: bench/dual_median_obstacle_detector_unit_tb.sv
// Self-checking testbench for dual_median_obstacle_detector_unit.
// Holds its own model of both median rings and of the obstacle flag, and
// depends only on dmod_pkg and the unit itself.
`timescale 1ns / 1ps

module dual_median_obstacle_detector_unit_tb;
  import dmod_pkg::*;

  localparam int WIN = 7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  dmod_in_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  dmod_out_t  out_data;
  logic       cfg_we = 1'b0;
  cfg_idx_t   cfg_index = CFG_ACCEPT_MIN;
  logic [VAL_W-1:0] cfg_wdata = '0;

  dual_median_obstacle_detector_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Model state: configuration, both rings and the last obstacle flag.
  int unsigned acc_min, acc_max, stop_dist, ready_need;
  int unsigned ring [2][WIN];
  int unsigned wr_pos [2];
  int unsigned fill [2];
  bit          obstacle_last;

  dmod_in_t    pending_q [$];
  dmod_out_t   expected_q [$];
  int          errors = 0;
  int          results_seen = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  function automatic void model_reset();
    int i;
    acc_min    = ACCEPT_MIN_RST;
    acc_max    = ACCEPT_MAX_RST;
    stop_dist  = STOP_DIST_RST;
    ready_need = READY_COUNT_RST;
    for (i = 0; i < WIN; i++) begin
      ring[0][i] = NOT_READY;
      ring[1][i] = NOT_READY;
    end
    wr_pos = '{0, 0};
    fill = '{0, 0};
    obstacle_last = 1'b0;
  endfunction

  function automatic bit reading_ok(int unsigned v);
    if (v == FAULT_ZERO || v == FAULT_LOW || v == FAULT_HIGH || v == FAULT_RANGE)
      return 1'b0;
    return (v >= acc_min) && (v <= acc_max);
  endfunction

  function automatic void ring_push(int side, int unsigned v);
    if (!reading_ok(v))
      return;
    ring[side][wr_pos[side]] = v & 32'h3FFF;
    wr_pos[side] = (wr_pos[side] + 1) % WIN;
    if (fill[side] < WIN)
      fill[side]++;
  endfunction

  // Sorts only the filled entries; for an even count the upper middle wins.
  function automatic int unsigned ring_median(int side, output bit ready);
    int unsigned sorted [WIN];
    int unsigned n, v;
    int i, j;
    n = fill[side];
    ready = 1'b0;
    if (n == 0 || n < ready_need)
      return NOT_READY;
    for (i = 0; i < n; i++) begin
      v = ring[side][i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    ready = 1'b1;
    return sorted[n/2];
  endfunction

  function automatic dmod_out_t predict_result(dmod_in_t it);
    dmod_out_t   r;
    int unsigned lm, rm;
    bit          lr, rr, obs;
    ring_push(0, it.left_raw);
    ring_push(1, it.right_raw);
    lm = ring_median(0, lr);
    rm = ring_median(1, rr);
    obs = (lr && lm < stop_dist) || (rr && rm < stop_dist);
    r.left_median      = lm[VAL_W-1:0];
    r.right_median     = rm[VAL_W-1:0];
    r.obstacle         = obs;
    r.obstacle_changed = (obs != obstacle_last);
    obstacle_last = obs;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_result(in_data));
        void'(pending_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_q[0];
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern switches at random among none, light, heavy and periodic.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    dmod_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no item pending, left_median", out_data.left_median, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.left_median !== want.left_median)
          report_mismatch("left_median", out_data.left_median, want.left_median);
        if (out_data.right_median !== want.right_median)
          report_mismatch("right_median", out_data.right_median, want.right_median);
        if (out_data.obstacle !== want.obstacle)
          report_mismatch("obstacle", out_data.obstacle, want.obstacle);
        if (out_data.obstacle_changed !== want.obstacle_changed)
          report_mismatch("obstacle_changed", out_data.obstacle_changed,
                          want.obstacle_changed);
      end
      results_seen++;
    end
  end

  task automatic push_item(int unsigned l, int unsigned r);
    dmod_in_t it;
    it.left_raw  = l[RAW_W-1:0];
    it.right_raw = r[RAW_W-1:0];
    pending_q.push_back(it);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[VAL_W-1:0];
    case (idx)
      CFG_ACCEPT_MIN: acc_min    = val & 32'h3FFF;
      CFG_ACCEPT_MAX: acc_max    = val & 32'h3FFF;
      CFG_STOP_DIST:  stop_dist  = val & 32'h3FFF;
      default:        ready_need = val & 32'h7;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_centre();
    if ($urandom_range(0, 1) == 0 && acc_min <= acc_max)
      return $urandom_range(acc_min, acc_max);
    return int'(stop_dist) + int'($urandom_range(0, 120)) - 60;
  endfunction

  // Mostly readings near a centre picked anew every eight items, so the medians cross the
  // stop distance; the rest are failure codes, window edges and noise.
  function automatic int unsigned make_reading(int centre);
    int v;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 11) begin
      v = centre + int'($urandom_range(0, 80)) - 40;
    end else if (sel < 13) begin
      case ($urandom_range(0, 3))
        0:       v = FAULT_ZERO;
        1:       v = FAULT_LOW;
        2:       v = FAULT_HIGH;
        default: v = FAULT_RANGE;
      endcase
    end else if (sel < 15) begin
      case ($urandom_range(0, 3))
        0:       v = int'(acc_min) - 1;
        1:       v = acc_min;
        2:       v = acc_max;
        default: v = acc_max + 1;
      endcase
    end else if (sel < 18) begin
      v = $urandom_range(0, 65535);
    end else if (acc_min <= acc_max) begin
      v = $urandom_range(acc_min, acc_max);
    end else begin
      v = $urandom_range(0, 16383);
    end
    if (v < 0)
      v = 0;
    if (v > 65535)
      v = 65535;
    return v;
  endfunction

  task automatic run_phase(int unsigned lo, int unsigned hi, int unsigned stop,
                           int unsigned need, int count);
    int k, cl, cr;
    write_reg(CFG_ACCEPT_MIN, lo);
    write_reg(CFG_ACCEPT_MAX, hi);
    write_reg(CFG_STOP_DIST, stop);
    write_reg(CFG_READY_COUNT, need);
    @(posedge clk);
    cfg_we <= 1'b0;
    for (k = 0; k < count; k++) begin
      if (k % 8 == 0) begin
        cl = pick_centre();
        cr = pick_centre();
      end
      push_item(make_reading(cl), make_reading(cr));
    end
    wait_idle();
  endtask

  initial begin
    model_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Register defaults: extremes, failure codes and the window edges.
    push_item(0, 65535);
    push_item(20, 8190);
    push_item(9999, 29);
    push_item(30, 2000);      // first samples, not ready yet
    push_item(2001, 150);
    push_item(100, 1999);     // right side becomes ready
    push_item(120, 16383);    // left median drops below the stop distance
    push_item(500, 31);       // even count takes the upper middle
    push_item(65534, 32768);
    push_item(1, 10000);
    push_item(8191, 8189);
    push_item(1500, 1800);
    push_item(1600, 1700);
    push_item(1700, 1600);
    push_item(1800, 190);     // ring wraps on the left
    push_item(1900, 180);
    push_item(199, 170);
    push_item(198, 160);
    push_item(21, 19);
    push_item(1999, 1998);
    wait_idle();

    run_phase(30, 2000, 200, 3, 100);
    // Widest accept window: codes up to the 14-bit limit are stored.
    run_phase(0, 16383, 16383, 7, 80);
    run_phase(9998, 9998, 0, 1, 40);
    // No samples required: a side is ready as soon as it holds one.
    run_phase(1, 600, 300, 0, 100);
    // Empty window rejects everything; only the low bits set the count.
    run_phase(700, 100, 9998, 14'h3FFA, 40);
    run_phase(30, 2000, 400, 5, 140);

    repeat (8) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/dmod_pkg.sv
rtl/dmod_ring.sv
rtl/dmod_select.sv
rtl/dual_median_obstacle_detector_unit.sv
rtl/dmod_checker.sv
bench/dual_median_obstacle_detector_unit_tb.sv
